// ===== design/uart_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uart_pkg;

    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned PERIOD_W          = 16;
    localparam int unsigned RX_TIMER_W        = PERIOD_W + 1;
    localparam int unsigned DATA_BITS_DEFAULT = 8;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd105;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD       = 16'd2;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_START,
        TX_DATA,
        TX_STOP
    } tx_phase_t;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_FIRST,
        RX_DATA,
        RX_STOP,
        RX_GUARD,
        RX_WAITHIGH
    } rx_phase_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              frame_error;
    } rx_status_t;

    typedef struct packed {
        tx_status_t tx;
        rx_status_t rx;
    } result_t;

    // Clamp very short bit periods to the shortest usable length.
    function automatic logic [PERIOD_W-1:0] period_clamp(input logic [PERIOD_W-1:0] p);
        return (p < MIN_PERIOD) ? MIN_PERIOD : p;
    endfunction

endpackage

`default_nettype wire

// ===== design/uart_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface uart_tick_if;
    logic                       valid;
    logic                       ready;
    logic                       rx_line;
    logic                       tx_start;
    logic [uart_pkg::BYTE_W-1:0] tx_byte;

    modport source (output valid, output rx_line, output tx_start, output tx_byte,
                    input ready);
    modport sink   (input valid, input rx_line, input tx_start, input tx_byte,
                    output ready);
endinterface

interface uart_result_if;
    logic                       valid;
    logic                       ready;
    logic                       tx_line;
    logic                       tx_busy;
    logic                       rx_valid;
    logic [uart_pkg::BYTE_W-1:0] rx_byte;
    logic                       rx_frame_error;

    modport source (output valid, output tx_line, output tx_busy, output rx_valid,
                    output rx_byte, output rx_frame_error, input ready);
    modport sink   (input valid, input tx_line, input tx_busy, input rx_valid,
                    input rx_byte, input rx_frame_error, output ready);
endinterface

interface uart_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [uart_pkg::PERIOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/uart_tx.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uart_tx #(
    parameter int unsigned DATA_BITS = uart_pkg::DATA_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          start,
    input  wire logic [uart_pkg::BYTE_W-1:0]   data,
    input  wire logic [uart_pkg::PERIOD_W-1:0] period,
    output uart_pkg::tx_status_t               status
);

    localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

    uart_pkg::tx_phase_t           phase_reg, phase_next;
    logic [uart_pkg::BYTE_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [uart_pkg::PERIOD_W-1:0] timer_reg, timer_next;
    logic                          level_reg, level_next;
    logic [uart_pkg::PERIOD_W-1:0] timer_dec;

    assign timer_dec = timer_reg - uart_pkg::PERIOD_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        level_next = level_reg;
        if (phase_reg == uart_pkg::TX_IDLE)
        begin
            level_next = 1'b1;
            if (start)
            begin
                shift_next = data;
                cnt_next   = '0;
                level_next = 1'b0;
                timer_next = period;
                phase_next = uart_pkg::TX_START;
            end
        end
        else
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                if (phase_reg == uart_pkg::TX_STOP)
                begin
                    phase_next = uart_pkg::TX_IDLE;
                    level_next = 1'b1;
                end
                else if (phase_reg == uart_pkg::TX_DATA && 32'(cnt_reg) >= 32'(DATA_BITS))
                begin
                    phase_next = uart_pkg::TX_STOP;
                    level_next = 1'b1;
                    timer_next = period;
                end
                else
                begin
                    // Bits past the byte shift out as zero.
                    phase_next = uart_pkg::TX_DATA;
                    level_next = shift_reg[0];
                    shift_next = {1'b0, shift_reg[uart_pkg::BYTE_W-1:1]};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    timer_next = period;
                end
            end
        end
    end

    assign status.line = level_next;
    assign status.busy = (phase_next != uart_pkg::TX_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uart_pkg::TX_IDLE;
            shift_reg <= '0;
            cnt_reg   <= '0;
            timer_reg <= '0;
            level_reg <= 1'b1;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            level_reg <= level_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == uart_pkg::TX_IDLE |-> level_reg)
        else $error("tx line low while idle");
    a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
        en && start && phase_reg == uart_pkg::TX_IDLE |=>
        !level_reg && phase_reg == uart_pkg::TX_START)
        else $error("start bit not driven after request");
`endif

endmodule

`default_nettype wire

// ===== design/uart_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uart_rx #(
    parameter int unsigned DATA_BITS = uart_pkg::DATA_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          line,
    input  wire logic [uart_pkg::PERIOD_W-1:0] period,
    output uart_pkg::rx_status_t               status
);

    localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);
    localparam int unsigned TW    = uart_pkg::RX_TIMER_W;

    uart_pkg::rx_phase_t         phase_reg, phase_next;
    logic [TW-1:0]               timer_reg, timer_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [uart_pkg::BYTE_W-1:0] shift_reg, shift_next;
    logic [TW-1:0]               timer_dec;
    logic [TW-1:0]               first_wait;
    logic [TW-1:0]               full_wait;
    logic [TW-1:0]               half_wait;

    assign timer_dec  = timer_reg - TW'(1);
    assign full_wait  = {1'b0, period};
    assign half_wait  = {2'b00, period[uart_pkg::PERIOD_W-1:1]};
    assign first_wait = full_wait + half_wait;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        status     = '0;
        unique case (phase_reg)
            uart_pkg::RX_IDLE:
            begin
                if (!line)
                begin
                    shift_next = '0;
                    cnt_next   = '0;
                    timer_next = first_wait;
                    phase_next = uart_pkg::RX_FIRST;
                end
            end
            uart_pkg::RX_WAITHIGH:
            begin
                if (line)
                    phase_next = uart_pkg::RX_IDLE;
            end
            uart_pkg::RX_FIRST, uart_pkg::RX_DATA, uart_pkg::RX_STOP, uart_pkg::RX_GUARD:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                begin
                    if (phase_reg == uart_pkg::RX_GUARD)
                        phase_next = uart_pkg::RX_IDLE;
                    else if (phase_reg == uart_pkg::RX_STOP)
                    begin
                        if (line)
                        begin
                            status.valid = 1'b1;
                            status.data  = shift_reg;
                            timer_next   = half_wait;
                            phase_next   = uart_pkg::RX_GUARD;
                        end
                        else
                        begin
                            status.frame_error = 1'b1;
                            phase_next         = uart_pkg::RX_WAITHIGH;
                        end
                    end
                    else
                    begin
                        // Drop samples past the byte.
                        if (line && 32'(cnt_reg) < 32'(uart_pkg::BYTE_W))
                            shift_next[cnt_reg[2:0]] = 1'b1;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        timer_next = full_wait;
                        phase_next = (32'(cnt_next) >= 32'(DATA_BITS)) ?
                                     uart_pkg::RX_STOP : uart_pkg::RX_DATA;
                    end
                end
            end
            default:
                phase_next = uart_pkg::RX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uart_pkg::RX_IDLE;
            timer_reg <= '0;
            cnt_reg   <= '0;
            shift_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

`ifndef SYNTHESIS
    a_done_from_stop: assert property (@(posedge clk) disable iff (!rst_n)
        en && (status.valid || status.frame_error) |->
        phase_reg == uart_pkg::RX_STOP && timer_reg == TW'(1))
        else $error("rx result outside stop sample");
    a_guard_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        en && status.valid |=> phase_reg == uart_pkg::RX_GUARD)
        else $error("no guard after good byte");
`endif

endmodule

`default_nettype wire

// ===== design/uart_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uart_skid (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  uart_pkg::result_t in_data,
    uart_result_if.source    result
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    uart_pkg::result_t out_data_reg, out_data_next;
    uart_pkg::result_t skid_data_reg, skid_data_next;
    logic              push;
    logic              out_free;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = in_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // Park the request while the output is stalled.
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.tx_line        = out_data_reg.tx.line;
    assign result.tx_busy        = out_data_reg.tx.busy;
    assign result.rx_valid       = out_data_reg.rx.valid;
    assign result.rx_byte        = out_data_reg.rx.data;
    assign result.rx_frame_error = out_data_reg.rx.frame_error;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result with output empty");
`endif

endmodule

`default_nettype wire

// ===== design/uart_8n1_tx_rx_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 8N1 serial transmitter and receiver driven by timing ticks.
// Channels:
//   tick   - one request per timing tick: sampled rx_line, tx_start, tx_byte.
//   result - one result per tick: tx_line, tx_busy, rx_valid, rx_byte,
//            rx_frame_error, showing the state after that tick.
//   cfg    - write of bit_period (ticks per serial bit); always ready.
//            Write it only while no tick result is pending.
// Each tick result is registered in the output register, or in the skid
// register while the sink stalls. Throughput: one tick per clock while
// tick.ready is high; the state machines update from their registers.
// A two-entry output buffer (output register plus skid register) lets a
// tick be taken while the previous result waits. When the result sink
// stalls, one more tick is taken into the skid register, then tick.ready
// drops until the sink takes a result.
// Reset (rst_n, asynchronous, low): both sides idle, tx line high,
// bit_period back to 105, output buffer empty.
module uart_8n1_tx_rx_unit #(
    parameter int unsigned DATA_BITS = uart_pkg::DATA_BITS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    uart_tick_if.sink     tick,
    uart_result_if.source result,
    uart_cfg_if.sink      cfg
);

    logic [uart_pkg::PERIOD_W-1:0] bit_period_reg;
    logic [uart_pkg::PERIOD_W-1:0] period;
    logic                          accept;
    uart_pkg::tx_status_t          tx_status;
    uart_pkg::rx_status_t          rx_status;
    uart_pkg::result_t             tick_result;

    // Configuration writes never stall.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_period_reg <= uart_pkg::BIT_PERIOD_RESET;
        else if (cfg.valid)
            bit_period_reg <= cfg.data;
    end

    assign period = uart_pkg::period_clamp(bit_period_reg);
    assign accept = tick.valid && tick.ready;

    // Advance both state machines once per accepted tick.
    uart_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept),
        .start  (tick.tx_start),
        .data   (tick.tx_byte),
        .period (period),
        .status (tx_status)
    );

    uart_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept),
        .line   (tick.rx_line),
        .period (period),
        .status (rx_status)
    );

    assign tick_result.tx = tx_status;
    assign tick_result.rx = rx_status;

    // Hold each result until the sink takes it.
    uart_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tick.valid),
        .in_ready (tick.ready),
        .in_data  (tick_result),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.rx_valid && result.rx_frame_error))
        else $error("byte and framing error on the same tick");
    a_result_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted tick gave no result");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DATA_BITS   = uart_pkg::DATA_BITS_DEFAULT;
    localparam int          STALL_LIMIT = 2000;   // cycles with no handshake at all
    localparam int          DRAIN_LIMIT = 5000;   // cycles allowed for the final drain

    // Where the receive line of each tick comes from.
    typedef enum logic [1:0] {
        LINE_LOOP,
        LINE_PLAN,
        LINE_NOISE
    } line_src_t;

    logic clk = 1'b0;
    logic rst_n;

    uart_tick_if   tick_bus ();
    uart_result_if status_bus ();
    uart_cfg_if    cfg_bus ();

    uart_8n1_tx_rx_unit #(
        .DATA_BITS (DATA_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_bus),
        .result (status_bus),
        .cfg    (cfg_bus)
    );

    // 4 ns period: high half, then low half.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        calm;              // suspend idling on both sides for a stretch
    line_src_t line_src;
    bit        auto_frames;       // refill the line plan with random frames

    logic              line_plan[$];     // receive line levels, one per tick
    logic [7:0]        tx_byte_plan[$];  // bytes to hand over on the next taken send requests
    uart_pkg::result_t expected_pins[$]; // predicted pins, oldest first

    int fail_count;
    int n_ticks;
    int n_cfg_writes;
    int n_tx_frames;
    int n_rx_bytes;
    int n_frame_errs;

    uart_pkg::result_t got_pins;
    uart_pkg::result_t want_pins;
    int                idle_cycles;

    // Copy of the unit's state, advanced once per taken tick request.
    logic [15:0]         cur_period;
    uart_pkg::tx_phase_t m_tx_ph;
    logic [7:0]          m_tx_sh;
    logic [3:0]          m_tx_cnt;
    logic [15:0]         m_tx_tmr;
    logic                m_tx_lvl;
    uart_pkg::rx_phase_t m_rx_ph;
    logic [16:0]         m_rx_tmr;
    logic [3:0]          m_rx_cnt;
    logic [7:0]          m_rx_sh;

    // ------------------------------------------------------------------
    // Prediction of one tick: transmitter first, then receiver, and the
    // pins as they look after this tick's update.
    // ------------------------------------------------------------------
    task automatic advance_uart_model(input logic line_in, input logic start_in,
                                      input logic [7:0] data_in,
                                      output uart_pkg::result_t pins);
        logic [15:0] per;
        per  = (cur_period < uart_pkg::MIN_PERIOD) ? uart_pkg::MIN_PERIOD : cur_period;
        pins = '0;

        // Transmitter: a request counts only when idle at the start of the tick.
        if (m_tx_ph == uart_pkg::TX_IDLE)
        begin
            m_tx_lvl = 1'b1;
            if (start_in)
            begin
                m_tx_sh  = data_in;
                m_tx_cnt = 4'd0;
                m_tx_lvl = 1'b0;
                m_tx_tmr = per;
                m_tx_ph  = uart_pkg::TX_START;
                n_tx_frames++;
            end
        end
        else
        begin
            m_tx_tmr = m_tx_tmr - 16'd1;
            if (m_tx_tmr == 16'd0)
            begin
                if (m_tx_ph == uart_pkg::TX_STOP)
                begin
                    m_tx_ph  = uart_pkg::TX_IDLE;
                    m_tx_lvl = 1'b1;
                end
                else if (m_tx_ph == uart_pkg::TX_DATA && m_tx_cnt >= DATA_BITS)
                begin
                    m_tx_ph  = uart_pkg::TX_STOP;
                    m_tx_lvl = 1'b1;
                    m_tx_tmr = per;
                end
                else
                begin
                    m_tx_ph  = uart_pkg::TX_DATA;
                    m_tx_lvl = m_tx_sh[0];
                    m_tx_sh  = m_tx_sh >> 1;
                    m_tx_cnt = m_tx_cnt + 4'd1;
                    m_tx_tmr = per;
                end
            end
        end

        // Receiver.
        case (m_rx_ph)
            uart_pkg::RX_IDLE:
            begin
                if (!line_in)
                begin
                    m_rx_sh  = 8'd0;
                    m_rx_cnt = 4'd0;
                    m_rx_tmr = {1'b0, per} + {2'b00, per[15:1]};
                    m_rx_ph  = uart_pkg::RX_FIRST;
                end
            end
            uart_pkg::RX_WAITHIGH:
            begin
                if (line_in)
                    m_rx_ph = uart_pkg::RX_IDLE;
            end
            uart_pkg::RX_FIRST, uart_pkg::RX_DATA, uart_pkg::RX_STOP, uart_pkg::RX_GUARD:
            begin
                m_rx_tmr = m_rx_tmr - 17'd1;
                if (m_rx_tmr == 17'd0)
                begin
                    if (m_rx_ph == uart_pkg::RX_GUARD)
                        m_rx_ph = uart_pkg::RX_IDLE;
                    else if (m_rx_ph == uart_pkg::RX_STOP)
                    begin
                        if (line_in)
                        begin
                            pins.rx.valid = 1'b1;
                            pins.rx.data  = m_rx_sh;
                            m_rx_tmr      = {2'b00, per[15:1]};
                            m_rx_ph       = uart_pkg::RX_GUARD;
                            n_rx_bytes++;
                        end
                        else
                        begin
                            pins.rx.frame_error = 1'b1;
                            m_rx_ph             = uart_pkg::RX_WAITHIGH;
                            n_frame_errs++;
                        end
                    end
                    else
                    begin
                        // Mid-bit sample; bits past the eighth are dropped.
                        if (line_in && m_rx_cnt < 4'd8)
                            m_rx_sh[m_rx_cnt[2:0]] = 1'b1;
                        m_rx_cnt = m_rx_cnt + 4'd1;
                        m_rx_tmr = {1'b0, per};
                        m_rx_ph  = (m_rx_cnt >= DATA_BITS) ? uart_pkg::RX_STOP
                                                           : uart_pkg::RX_DATA;
                    end
                end
            end
            default:
                m_rx_ph = uart_pkg::RX_IDLE;
        endcase

        pins.tx.line = m_tx_lvl;
        pins.tx.busy = (m_tx_ph != uart_pkg::TX_IDLE);
    endtask

    // ------------------------------------------------------------------
    // Send one tick request. Idle the request first at random, then hold
    // it until the unit takes it and queue the predicted pins. Valid stays
    // high on return; the caller must send again or drain before the next
    // falling edge.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic line_in, input logic start_in,
                             input logic [7:0] data_in);
        uart_pkg::result_t want;
        logic              was_idle;
        while (!calm && $urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            tick_bus.valid <= 1'b0;
        end
        @(negedge clk);
        tick_bus.valid    <= 1'b1;
        tick_bus.rx_line  <= line_in;
        tick_bus.tx_start <= start_in;
        tick_bus.tx_byte  <= data_in;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        was_idle = (m_tx_ph == uart_pkg::TX_IDLE);
        advance_uart_model(line_in, start_in, data_in, want);
        if (start_in && was_idle && tx_byte_plan.size() != 0)
            void'(tx_byte_plan.pop_front());
        expected_pins.push_back(want);
        n_ticks++;
    endtask

    // Drop the request and hold off until every predicted result is back.
    task automatic wait_for_results();
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
    endtask

    // Write bit_period while nothing is in flight.
    task automatic write_bit_period(input logic [15:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cur_period = value;
        n_cfg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Queue one serial frame on the receive line: start, 8 data bits LSB
    // first, stop at the given level, then idle-high ticks. Jitter stretches
    // or shrinks each bit by up to one tick when the period is at least 3.
    task automatic plan_frame(input logic [7:0] data, input logic stop_hi,
                              input bit jitter, input int idle_after);
        logic [9:0] frame;
        int         per;
        int         b;
        int         len;
        frame = {stop_hi, data, 1'b0};
        per   = (cur_period < uart_pkg::MIN_PERIOD) ? uart_pkg::MIN_PERIOD : cur_period;
        for (b = 0; b < 10; b++)
        begin
            len = per;
            if (jitter && per >= 3)
                len = per - 1 + $urandom_range(0, 2);
            repeat (len)
                line_plan.push_back(frame[b]);
        end
        repeat (idle_after)
            line_plan.push_back(1'b1);
    endtask

    // Send up to max_ticks ticks. Each tick asks to send with start_pct
    // percent; with stop_when_quiet set, stop early once both sides are idle and the plan is spent.
    task automatic run_ticks(input int max_ticks, input int start_pct,
                             input bit stop_when_quiet);
        logic       line_v;
        logic       start_v;
        logic [7:0] data_v;
        int         k;
        int         kind;
        int         per;
        for (k = 0; k < max_ticks; k++)
        begin
            if (stop_when_quiet && m_tx_ph == uart_pkg::TX_IDLE
                && m_rx_ph == uart_pkg::RX_IDLE && line_plan.size() == 0)
                break;
            case (line_src)
                LINE_LOOP:  line_v = m_tx_lvl;
                LINE_NOISE: line_v = ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (line_plan.size() == 0 && auto_frames)
                    begin
                        per  = (cur_period < uart_pkg::MIN_PERIOD) ? uart_pkg::MIN_PERIOD
                                                                   : cur_period;
                        kind = $urandom_range(0, 99);
                        if (kind < 80)
                            plan_frame(8'($urandom_range(0, 255)), 1'b1,
                                       $urandom_range(0, 3) == 0,
                                       $urandom_range(0, 2 * per));
                        else if (kind < 92)
                        begin
                            // Low stop bit, then the line may stay low a while.
                            plan_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0, 0);
                            repeat ($urandom_range(0, 4))
                                line_plan.push_back(1'b0);
                        end
                        else
                        begin
                            // A lone low tick looks like a start bit.
                            line_plan.push_back(1'b0);
                            repeat ($urandom_range(1, 3))
                                line_plan.push_back(1'b1);
                        end
                    end
                    line_v = (line_plan.size() != 0) ? line_plan.pop_front() : 1'b1;
                end
            endcase
            start_v = ($urandom_range(0, 99) < start_pct);
            data_v  = 8'($urandom_range(0, 255));
            if (tx_byte_plan.size() != 0)
                data_v = tx_byte_plan[0];
            send_tick(line_v, start_v, data_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Start one frame at the reset bit period, looped back into the receiver.
    // Once the start bit has run its full reset length, shorten the period so
    // the rest of the frame finishes quickly.
    task automatic test_reset_period();
        line_src = LINE_LOOP;
        tx_byte_plan.push_back(8'h3C);
        run_ticks(1, 100, 1'b0);
        run_ticks(120, 0, 1'b0);
        write_bit_period(16'd4);
        run_ticks(600, 0, 1'b1);
    endtask

    // Period 0 clamps to 2. Hold the send request high through the first
    // run, so requests while busy and on the tick that ends a stop bit are ignored.
    task automatic test_tx_back_to_back();
        write_bit_period(16'd0);
        line_src = LINE_LOOP;
        tx_byte_plan.push_back(8'h00);
        tx_byte_plan.push_back(8'hFF);
        tx_byte_plan.push_back(8'h80);
        tx_byte_plan.push_back(8'h01);
        run_ticks(90, 100, 1'b0);
        run_ticks(100, 0, 1'b1);
    endtask

    // Receiver cases at period 1 (clamped to 2): good byte, framing error
    // with the line held low, one-tick glitch, frames packed into the guard.
    task automatic test_rx_framing();
        write_bit_period(16'd1);
        line_src    = LINE_PLAN;
        auto_frames = 1'b0;
        plan_frame(8'h5A, 1'b1, 1'b0, 3);
        plan_frame(8'h3C, 1'b0, 1'b0, 0);
        repeat (3)
            line_plan.push_back(1'b0);
        repeat (4)
            line_plan.push_back(1'b1);
        line_plan.push_back(1'b0);
        repeat (22)
            line_plan.push_back(1'b1);
        plan_frame(8'h00, 1'b1, 1'b0, 0);
        plan_frame(8'h81, 1'b1, 1'b0, 0);
        run_ticks(300, 0, 1'b1);
    endtask

    // Change the period while a frame is running: the running wait keeps
    // its loaded count and the new value applies at the next reload.
    task automatic test_period_change();
        write_bit_period(16'd3);
        line_src = LINE_LOOP;
        tx_byte_plan.push_back(8'hC3);
        run_ticks(7, 100, 1'b0);
        write_bit_period(16'd6);
        run_ticks(600, 0, 1'b1);
    endtask

    // Largest period: let both sides settle, start a frame and a receive,
    // then drop to the shortest period while the long first waits still run.
    task automatic test_large_period();
        line_src = LINE_LOOP;
        run_ticks(400, 0, 1'b1);
        write_bit_period(16'hFFFF);
        line_src    = LINE_PLAN;
        auto_frames = 1'b0;
        line_plan.push_back(1'b0);
        tx_byte_plan.push_back(8'h81);
        run_ticks(16, 100, 1'b0);
        write_bit_period(uart_pkg::MIN_PERIOD);
        run_ticks(40, 0, 1'b0);
    endtask

    // Random traffic in chunks of 50 ticks. Pick a new period every 100
    // ticks, and a new line source, send rate and idling per chunk.
    task automatic test_random_traffic(input int n);
        int i;
        int pick;
        auto_frames = 1'b1;
        for (i = 0; i < n; i += 50)
        begin
            if (i % 100 == 0)
            begin
                pick = $urandom_range(0, 7);
                case (pick)
                    0:       write_bit_period(16'd2);
                    1:       write_bit_period(16'd3);
                    2:       write_bit_period(16'($urandom_range(0, 1)));
                    3:       write_bit_period(16'd4);
                    4:       write_bit_period(16'd5);
                    default: write_bit_period(16'($urandom_range(2, 12)));
                endcase
            end
            else if ($urandom_range(0, 9) == 0)
                wait_for_results();   // pause until the unit has caught up
            pick = $urandom_range(0, 99);
            if (pick < 35)
                line_src = LINE_LOOP;
            else if (pick < 85)
                line_src = LINE_PLAN;
            else
                line_src = LINE_NOISE;
            calm = ($urandom_range(0, 3) == 0);
            run_ticks(50, $urandom_range(0, 30), 1'b0);
        end
        calm        = 1'b0;
        auto_frames = 1'b0;
        line_plan.delete();
    endtask

    // ------------------------------------------------------------------
    // Result side: stall at random, then check each result in order.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!calm && $urandom_range(0, 99) < recv_idle_pct)
            status_bus.ready <= 1'b0;
        else
            status_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && status_bus.valid && status_bus.ready)
        begin
            got_pins.tx.line        = status_bus.tx_line;
            got_pins.tx.busy        = status_bus.tx_busy;
            got_pins.rx.valid       = status_bus.rx_valid;
            got_pins.rx.data        = status_bus.rx_byte;
            got_pins.rx.frame_error = status_bus.rx_frame_error;
            if (expected_pins.size() == 0)
            begin
                $error("result arrived with no tick request pending");
                fail_count++;
            end
            else
            begin
                want_pins = expected_pins.pop_front();
                if (got_pins.tx.line !== want_pins.tx.line)
                begin
                    $error("tx_line mismatch: expected %0d actual %0d",
                           want_pins.tx.line, got_pins.tx.line);
                    fail_count++;
                end
                if (got_pins.tx.busy !== want_pins.tx.busy)
                begin
                    $error("tx_busy mismatch: expected %0d actual %0d",
                           want_pins.tx.busy, got_pins.tx.busy);
                    fail_count++;
                end
                if (got_pins.rx.valid !== want_pins.rx.valid)
                begin
                    $error("rx_valid mismatch: expected %0d actual %0d",
                           want_pins.rx.valid, got_pins.rx.valid);
                    fail_count++;
                end
                if (got_pins.rx.data !== want_pins.rx.data)
                begin
                    $error("rx_byte mismatch: expected %02h actual %02h",
                           want_pins.rx.data, got_pins.rx.data);
                    fail_count++;
                end
                if (got_pins.rx.frame_error !== want_pins.rx.frame_error)
                begin
                    $error("rx_frame_error mismatch: expected %0d actual %0d",
                           want_pins.rx.frame_error, got_pins.rx.frame_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_bus.valid && tick_bus.ready) || (status_bus.valid && status_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_pins.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int drain_cycles;

        // Drive every input to a known level from time zero.
        tick_bus.valid    = 1'b0;
        tick_bus.rx_line  = 1'b1;
        tick_bus.tx_start = 1'b0;
        tick_bus.tx_byte  = 8'd0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.data      = '0;
        send_idle_pct     = 16;
        recv_idle_pct     = 60;
        calm              = 1'b0;
        line_src          = LINE_LOOP;
        auto_frames       = 1'b0;
        fail_count        = 0;
        n_ticks           = 0;
        n_cfg_writes      = 0;
        n_tx_frames       = 0;
        n_rx_bytes        = 0;
        n_frame_errs      = 0;
        idle_cycles       = 0;

        // Model state after reset.
        cur_period = uart_pkg::BIT_PERIOD_RESET;
        m_tx_ph    = uart_pkg::TX_IDLE;
        m_tx_sh    = 8'd0;
        m_tx_cnt   = 4'd0;
        m_tx_tmr   = 16'd0;
        m_tx_lvl   = 1'b1;
        m_rx_ph    = uart_pkg::RX_IDLE;
        m_rx_tmr   = 17'd0;
        m_rx_cnt   = 4'd0;
        m_rx_sh    = 8'd0;

        // Hold reset low, then release it away from the rising edge.
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sender idles lightly, receiver stalls often.
        test_reset_period();
        test_tx_back_to_back();
        test_rx_framing();
        test_period_change();
        test_random_traffic(250);

        // Swap: sender idles often, receiver stalls lightly.
        send_idle_pct = 60;
        recv_idle_pct = 16;
        test_random_traffic(250);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(250);
        test_large_period();

        // Drop the request and wait for the last results.
        @(negedge clk);
        tick_bus.valid <= 1'b0;
        drain_cycles = 0;
        while (expected_pins.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (expected_pins.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_pins.size());
            fail_count++;
        end
        repeat (4)
            @(posedge clk);

        $display("Ran %0d ticks under %0d bit_period writes (0, 1, 2 and 65535 included)",
                 n_ticks, n_cfg_writes);
        $display("Frames sent %0d, bytes received %0d, framing errors %0d, failures %0d",
                 n_tx_frames, n_rx_bytes, n_frame_errs, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
